// ===== design/ffba_pkg.sv =====
// package for the first-fit block allocator: payload widths, codes and controller states
package ffba_pkg;

    localparam int DATA_W   = 17;
    localparam int STATUS_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_A_CHK,
        ST_A_SPLIT,
        ST_F_CHK,
        ST_M_RD0,
        ST_M_CUR,
        ST_M_CHK,
        ST_M_WB,
        ST_EMIT
    } state_t;

endpackage

// ===== design/first_fit_block_allocator_unit.sv =====
// first-fit block allocator with coalescing, block table held in one synchronous memory
//
// The pool is a chain of blocks in address order, each a header followed by its data
// area. The block table has one entry per alignment unit ({start, used, data units}) in a
// single memory with a registered read. After reset the controller sweeps the whole
// table, one entry a cycle (POOL_BYTES/ALIGN_BYTES entries, 12288 by default), and
// leaves one free block; no transaction is taken during that sweep. Each transaction is
// handled on its own. An allocate rounds the size through a reciprocal multiply, then
// checks it, walks the chain block by block through the memory read port, takes one
// extra step when the block is split, and then posts the result. A free converts the
// address to a unit index, checks it and marks the block free, then walks the whole
// chain, with an extra write-back step for every merge of neighboring free blocks,
// and then posts the result. A rejected size or address, or a free of an address that
// is not a used block start, is posted without a walk of the chain.
// After each result the block returns to idle, where the next transaction can be
// taken. The result sits in an output register, so a new transaction is taken while the
// last one waits.
module first_fit_block_allocator_unit #(
    parameter int POOL_BYTES   = 98304,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          opcode,
    input  logic [ffba_pkg::DATA_W-1:0]   request_bytes,
    input  logic [ffba_pkg::DATA_W-1:0]   block_address,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [ffba_pkg::STATUS_W-1:0] status,
    output logic [ffba_pkg::DATA_W-1:0]   data_address,
    output logic [ffba_pkg::DATA_W-1:0]   granted_bytes
);
    import ffba_pkg::*;

    // table geometry
    localparam int NUM_UNITS = POOL_BYTES / ALIGN_BYTES;
    localparam int HDR_UNITS = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int HDR_SIZE  = HDR_UNITS * ALIGN_BYTES;
    localparam int IW        = $clog2(NUM_UNITS);
    localparam int UW        = $clog2(NUM_UNITS + 1);
    localparam int EW        = UW + 2;
    localparam int SW        = IW + 1;
    localparam int PW        = $clog2(POOL_BYTES + 1);

    // rounding divider: request plus alignment-1 fits in one more bit than the field
    localparam int XW    = DATA_W + 1;
    localparam int SH    = XW + $clog2(ALIGN_BYTES);
    localparam int RW    = XW + 2;
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1)
                                          / 64'(ALIGN_BYTES));

    // common compare width
    localparam int MW1 = (XW > SW) ? XW : SW;
    localparam int MW2 = (MW1 > PW) ? MW1 : PW;
    localparam int WW  = MW2 + 2;

    localparam logic [WW-1:0] NUM_W   = WW'(NUM_UNITS);
    localparam logic [WW-1:0] HDR_W   = WW'(HDR_UNITS);
    localparam logic [WW-1:0] HSIZE_W = WW'(HDR_SIZE);
    localparam logic [WW-1:0] ALIGN_W = WW'(ALIGN_BYTES);
    localparam logic [WW-1:0] POOL_W  = WW'(POOL_BYTES);
    localparam logic [EW-1:0] INIT_ENTRY = {1'b1, 1'b0, UW'(NUM_UNITS - HDR_UNITS)};

    // block table
    logic [EW-1:0] mem [NUM_UNITS];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    // control and working registers
    state_t               state_reg, state_next;
    logic [IW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                 op_reg, op_next;
    logic [DATA_W-1:0]    req_reg, req_next;
    logic [DATA_W-1:0]    addr_reg, addr_next;
    logic [XW-1:0]        x_reg, x_next;
    logic                 low_reg, low_next;
    logic [XW-1:0]        q_reg, q_next;
    logic [IW-1:0]        b_reg, b_next;
    logic [IW-1:0]        n_reg, n_next;
    logic [UW-1:0]        cur_units_reg, cur_units_next;
    logic                 cur_used_reg, cur_used_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [IW-1:0]        res_blk_reg, res_blk_next;
    logic [UW-1:0]        res_units_reg, res_units_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [DATA_W-1:0]    data_address_reg, data_address_next;
    logic [DATA_W-1:0]    granted_bytes_reg, granted_bytes_next;

    // datapath terms
    logic [XW-1:0]    x_sel;
    logic [XW+RW-1:0] x_prod;
    logic             e_start;
    logic             e_used;
    logic [UW-1:0]    e_units;
    logic [WW-1:0]    need_w;
    logic [WW-1:0]    rd_base_w;
    logic [WW-1:0]    rd_next_w;
    logic [WW-1:0]    cur_next_w;
    logic [WW-1:0]    split_w;
    logic [WW-1:0]    merge_w;
    logic [WW-1:0]    q_times_a;
    logic             out_free;

    assign req_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign data_address  = data_address_reg;
    assign granted_bytes = granted_bytes_reg;

    // rounding / unit conversion: multiply by the reciprocal of the alignment
    assign x_sel  = (op_reg == OP_FREE) ? (XW'(addr_reg) - XW'(HDR_SIZE))
                                        : (XW'(req_reg) + XW'(ALIGN_BYTES - 1));
    assign x_prod = (XW+RW)'(x_sel) * (XW+RW)'(RECIP);

    // fields of the entry just read
    assign e_start = rdata_reg[EW-1];
    assign e_used  = rdata_reg[EW-2];
    assign e_units = rdata_reg[UW-1:0];

    assign need_w     = WW'(q_reg);
    assign q_times_a  = WW'(q_reg) * ALIGN_W;
    assign rd_base_w  = (state_reg == ST_M_CHK) ? WW'(n_reg) : WW'(b_reg);
    assign rd_next_w  = rd_base_w + HDR_W + WW'(e_units);
    assign cur_next_w = WW'(b_reg) + HDR_W + WW'(cur_units_reg);
    assign split_w    = WW'(b_reg) + HDR_W + need_w;
    assign merge_w    = WW'(cur_units_reg) + HDR_W + WW'(e_units);
    assign out_free   = !rsp_valid_reg || rsp_ready;

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        req_reg           <= req_next;
        addr_reg          <= addr_next;
        x_reg             <= x_next;
        low_reg           <= low_next;
        q_reg             <= q_next;
        b_reg             <= b_next;
        n_reg             <= n_next;
        cur_units_reg     <= cur_units_next;
        cur_used_reg      <= cur_used_next;
        res_status_reg    <= res_status_next;
        res_blk_reg       <= res_blk_next;
        res_units_reg     <= res_units_next;
        status_reg        <= status_next;
        data_address_reg  <= data_address_next;
        granted_bytes_reg <= granted_bytes_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        op_next            = op_reg;
        req_next           = req_reg;
        addr_next          = addr_reg;
        x_next             = x_reg;
        low_next           = low_reg;
        q_next             = q_reg;
        b_next             = b_reg;
        n_next             = n_reg;
        cur_units_next     = cur_units_reg;
        cur_used_next      = cur_used_reg;
        res_status_next    = res_status_reg;
        res_blk_next       = res_blk_reg;
        res_units_next     = res_units_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp_ready;
        status_next        = status_reg;
        data_address_next  = data_address_reg;
        granted_bytes_next = granted_bytes_reg;
        mem_we             = 1'b0;
        mem_waddr          = '0;
        mem_wdata          = '0;
        mem_re             = 1'b0;
        mem_raddr          = '0;

        case (state_reg)
            // sweep the table after reset, unit 0 gets the whole pool
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = (clr_cnt_reg == '0) ? INIT_ENTRY : '0;
                if (clr_cnt_reg == IW'(NUM_UNITS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = opcode;
                    req_next   = request_bytes;
                    addr_next  = block_address;
                    state_next = ST_DIV;
                end
            end

            // unit count of the request, or unit index of the freed block
            ST_DIV:
            begin
                x_next     = x_sel;
                q_next     = XW'(x_prod >> SH);
                low_next   = (XW'(addr_reg) < XW'(HDR_SIZE));
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if ((req_reg == '0) || (WW'(req_reg) > POOL_W))
                    begin
                        res_status_next = STATUS_NOFIT;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        b_next     = '0;
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = ST_A_CHK;
                    end
                end
                else
                begin
                    // off-grid, below the first data offset or past the pool
                    if (low_reg || (q_times_a != WW'(x_reg)) || (need_w >= NUM_W))
                    begin
                        res_status_next = STATUS_BADFREE;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        b_next     = IW'(q_reg);
                        mem_re     = 1'b1;
                        mem_raddr  = IW'(q_reg);
                        state_next = ST_F_CHK;
                    end
                end
            end

            // first-fit walk, one block per cycle
            ST_A_CHK:
            begin
                if (!e_start)
                begin
                    res_status_next = STATUS_NOFIT;
                    state_next      = ST_EMIT;
                end
                else if (!e_used && (WW'(e_units) >= need_w))
                begin
                    res_status_next = STATUS_OK;
                    res_blk_next    = b_reg;
                    if (WW'(e_units) >= need_w + HDR_W + WW'(1))
                    begin
                        // remainder becomes a new free block
                        mem_we         = 1'b1;
                        mem_waddr      = IW'(split_w);
                        mem_wdata      = {1'b1, 1'b0, UW'(WW'(e_units) - need_w - HDR_W)};
                        res_units_next = UW'(q_reg);
                        state_next     = ST_A_SPLIT;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = b_reg;
                        mem_wdata      = {1'b1, 1'b1, e_units};
                        res_units_next = e_units;
                        state_next     = ST_EMIT;
                    end
                end
                else if (rd_next_w >= NUM_W)
                begin
                    res_status_next = STATUS_NOFIT;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    b_next    = IW'(rd_next_w);
                    mem_re    = 1'b1;
                    mem_raddr = IW'(rd_next_w);
                end
            end

            ST_A_SPLIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = b_reg;
                mem_wdata  = {1'b1, 1'b1, res_units_reg};
                state_next = ST_EMIT;
            end

            ST_F_CHK:
            begin
                if (!e_start || !e_used)
                begin
                    res_status_next = STATUS_BADFREE;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = b_reg;
                    mem_wdata       = {1'b1, 1'b0, e_units};
                    res_status_next = STATUS_OK;
                    state_next      = ST_M_RD0;
                end
            end

            // coalescing pass over the whole chain
            ST_M_RD0:
            begin
                b_next     = '0;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_M_CUR;
            end

            ST_M_CUR:
            begin
                cur_units_next = e_units;
                cur_used_next  = e_used;
                if (rd_next_w >= NUM_W)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    n_next     = IW'(rd_next_w);
                    mem_re     = 1'b1;
                    mem_raddr  = IW'(rd_next_w);
                    state_next = ST_M_CHK;
                end
            end

            ST_M_CHK:
            begin
                if (!e_start)
                begin
                    state_next = ST_EMIT;
                end
                else if (!cur_used_reg && !e_used)
                begin
                    // absorb the neighbor, clear its header entry
                    mem_we         = 1'b1;
                    mem_waddr      = n_reg;
                    mem_wdata      = '0;
                    cur_units_next = UW'(merge_w);
                    state_next     = ST_M_WB;
                end
                else
                begin
                    b_next         = n_reg;
                    cur_units_next = e_units;
                    cur_used_next  = e_used;
                    if (rd_next_w >= NUM_W)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        n_next    = IW'(rd_next_w);
                        mem_re    = 1'b1;
                        mem_raddr = IW'(rd_next_w);
                    end
                end
            end

            // write back the grown block and fetch its new neighbor
            ST_M_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_reg;
                mem_wdata = {1'b1, 1'b0, cur_units_reg};
                if (cur_next_w >= NUM_W)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    n_next     = IW'(cur_next_w);
                    mem_re     = 1'b1;
                    mem_raddr  = IW'(cur_next_w);
                    state_next = ST_M_CHK;
                end
            end

            // post the transaction result once the output register is free
            ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    if (res_status_reg != STATUS_OK)
                    begin
                        data_address_next  = '0;
                        granted_bytes_next = '0;
                    end
                    else if (op_reg == OP_FREE)
                    begin
                        data_address_next  = addr_reg;
                        granted_bytes_next = '0;
                    end
                    else
                    begin
                        data_address_next  = DATA_W'(WW'(res_blk_reg) * ALIGN_W + HSIZE_W);
                        granted_bytes_next = DATA_W'(WW'(res_units_reg) * ALIGN_W);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read and write never hit the same entry in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("table read and write to the same entry");

    // walk never reads past the end of the table
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (WW'(mem_raddr) < NUM_W))
        else $error("table read beyond the pool");

    // a failed transaction reports no address and no size
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != STATUS_OK)) |-> ((data_address == '0) && (granted_bytes == '0)))
        else $error("failed transaction with nonzero payload");

    // one transaction at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second transaction taken while busy");

endmodule

// ===== dv/first_fit_block_allocator_unit_test.sv =====
// testbench for the first-fit block allocator: allocate/free traffic checked against a predictor
module first_fit_block_allocator_unit_test;

    import ffba_pkg::*;

    // block geometry, same defaults as the block
    localparam int POOL_BYTES   = 98304;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEADER_BYTES = 16;
    localparam int HDR_UNITS    = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int HDR_SIZE     = HDR_UNITS * ALIGN_BYTES;
    localparam int NUM_UNITS    = POOL_BYTES / ALIGN_BYTES;
    localparam int FIELD_MAX    = (1 << DATA_W) - 1;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] req_bytes;
        logic [DATA_W-1:0] blk_addr;
    } alloc_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_address;
        logic [DATA_W-1:0]   granted_bytes;
    } alloc_result_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                req_valid     = 1'b0;
    logic                req_ready;
    logic                opcode        = OP_ALLOC;
    logic [DATA_W-1:0]   request_bytes = '0;
    logic [DATA_W-1:0]   block_address = '0;
    logic                rsp_valid;
    logic                rsp_ready     = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_address;
    logic [DATA_W-1:0]   granted_bytes;

    first_fit_block_allocator_unit #(
        .POOL_BYTES   (POOL_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .request_bytes (request_bytes),
        .block_address (block_address),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .data_address  (data_address),
        .granted_bytes (granted_bytes)
    );

    // shadow block table: start flag, used flag and data size in units per alignment unit
    bit          blk_start [NUM_UNITS];
    bit          blk_used  [NUM_UNITS];
    int unsigned blk_units [NUM_UNITS];

    alloc_request_t pending_requests [$];
    alloc_result_t  expected_results [$];
    // data offsets of blocks granted so far and not yet picked for a free
    int unsigned    live_blocks [$];

    int  error_count    = 0;
    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    bit  req_taken      = 1'b0;
    bit  rsp_taken      = 1'b0;
    bit  calm_mode      = 1'b0;
    int  send_gap       = 0;
    int  recv_gap       = 0;

    alloc_request_t next_req;
    alloc_result_t  want;
    alloc_result_t  got;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length in cycles: none in calm mode, else mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_mode)
            return 0;
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // first-fit allocate or free with coalescing on the shadow table
    function automatic alloc_result_t predict_alloc_result(input logic op,
                                                           input logic [DATA_W-1:0] req,
                                                           input logic [DATA_W-1:0] addr);
        alloc_result_t r;
        int unsigned   need;
        int unsigned   b;
        int unsigned   s;
        int unsigned   n;
        int unsigned   u;
        r.status        = STATUS_NOFIT;
        r.data_address  = '0;
        r.granted_bytes = '0;
        if (op == OP_ALLOC)
        begin
            if (req == 0 || req > POOL_BYTES)
                return r;
            need = (req + ALIGN_BYTES - 1) / ALIGN_BYTES;
            b = 0;
            while (b < NUM_UNITS && blk_start[b])
            begin
                if (!blk_used[b] && blk_units[b] >= need)
                begin
                    // split only when the rest holds a header plus one unit
                    if (blk_units[b] >= need + HDR_UNITS + 1)
                    begin
                        s = b + HDR_UNITS + need;
                        if (s < NUM_UNITS)
                        begin
                            blk_start[s] = 1'b1;
                            blk_used[s]  = 1'b0;
                            blk_units[s] = blk_units[b] - need - HDR_UNITS;
                            blk_units[b] = need;
                        end
                    end
                    blk_used[b]     = 1'b1;
                    r.status        = STATUS_OK;
                    r.data_address  = DATA_W'(b * ALIGN_BYTES + HDR_SIZE);
                    r.granted_bytes = DATA_W'(blk_units[b] * ALIGN_BYTES);
                    live_blocks.push_back(b * ALIGN_BYTES + HDR_SIZE);
                    return r;
                end
                b = b + HDR_UNITS + blk_units[b];
            end
            return r;
        end
        r.status = STATUS_BADFREE;
        if (addr < HDR_SIZE || ((addr - HDR_SIZE) % ALIGN_BYTES) != 0)
            return r;
        u = (addr - HDR_SIZE) / ALIGN_BYTES;
        if (u >= NUM_UNITS || !blk_start[u] || !blk_used[u])
            return r;
        blk_used[u] = 1'b0;
        // walk the whole chain, folding each free neighbor into the block before it
        b = 0;
        while (b < NUM_UNITS && blk_start[b])
        begin
            n = b + HDR_UNITS + blk_units[b];
            if (n >= NUM_UNITS || !blk_start[n])
                break;
            if (!blk_used[b] && !blk_used[n])
            begin
                blk_units[b] = blk_units[b] + HDR_UNITS + blk_units[n];
                blk_start[n] = 1'b0;
                blk_units[n] = 0;
            end
            else
                b = n;
        end
        r.status       = STATUS_OK;
        r.data_address = addr;
        return r;
    endfunction

    // request side: one transaction from the pending queue at a time, random gaps between
    always @(negedge clk)
    begin
        logic valid_next;
        if (req_taken)
        begin
            req_taken  = 1'b0;
            valid_next = 1'b0;
        end
        else
            valid_next = req_valid;
        if (!valid_next)
        begin
            if (send_gap > 0)
                send_gap = send_gap - 1;
            else if (pending_requests.size() > 0)
            begin
                next_req = pending_requests.pop_front();
                valid_next = 1'b1;
                opcode        <= next_req.op;
                request_bytes <= next_req.req_bytes;
                block_address <= next_req.blk_addr;
                send_gap = pick_gap();
            end
        end
        req_valid <= valid_next;
    end

    // response side: random backpressure, a new stall length drawn after each transaction
    always @(negedge clk)
    begin
        if (rsp_taken)
        begin
            rsp_taken = 1'b0;
            recv_gap  = pick_gap();
        end
        if (recv_gap > 0)
        begin
            recv_gap = recv_gap - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            expected_results.push_back(predict_alloc_result(opcode, request_bytes,
                                                            block_address));
            req_taken = 1'b1;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_taken = 1'b1;
            results_seen = results_seen + 1;
            got.status        = status;
            got.data_address  = data_address;
            got.granted_bytes = granted_bytes;
            if (expected_results.size() == 0)
            begin
                error_count = error_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result: status %0d addr %0d bytes %0d",
                             got.status, got.data_address, got.granted_bytes);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.data_address !== want.data_address ||
                    got.granted_bytes !== want.granted_bytes)
                begin
                    error_count = error_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: status %0d/%0d addr %0d/%0d bytes %0d/%0d (exp/act)",
                                 want.status, got.status, want.data_address, got.data_address,
                                 want.granted_bytes, got.granted_bytes);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // keep the pending queue short so frees pick from a fresh list of live blocks
    task automatic enqueue_request(input alloc_request_t item);
        while (pending_requests.size() >= 2)
            @(negedge clk);
        pending_requests.push_back(item);
        items_sent = items_sent + 1;
    endtask

    task automatic push_alloc(input int unsigned bytes);
        alloc_request_t item;
        item.op        = OP_ALLOC;
        item.req_bytes = DATA_W'(bytes);
        item.blk_addr  = DATA_W'($urandom_range(0, FIELD_MAX));
        enqueue_request(item);
    endtask

    task automatic push_free(input int unsigned addr);
        alloc_request_t item;
        item.op        = OP_FREE;
        item.req_bytes = DATA_W'($urandom_range(0, FIELD_MAX));
        item.blk_addr  = DATA_W'(addr);
        enqueue_request(item);
    endtask

    // sender holds off until the block has returned every outstanding result
    task automatic wait_drained();
        while (results_seen != items_sent)
            @(negedge clk);
    endtask

    // request sizes: mostly small, a few big enough to exhaust the pool
    function automatic int unsigned random_alloc_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 256);
        if (roll < 92)
            return $urandom_range(257, 4096);
        if (roll < 98)
            return $urandom_range(4097, 32768);
        return $urandom_range(32769, FIELD_MAX);
    endfunction

    task automatic push_random_mix(input int count);
        int          k;
        int          pick;
        int          idx;
        int unsigned addr;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50 || (live_blocks.size() == 0 && pick < 85))
                push_alloc(random_alloc_size());
            else if (pick < 85)
            begin
                idx  = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[idx];
                live_blocks.delete(idx);
                push_free(addr);
                // now and then a double free right behind it
                if ($urandom_range(0, 19) == 0)
                    push_free(addr);
            end
            else
            begin
                case (pick % 5)
                    0: push_alloc(0);
                    1: push_alloc($urandom_range(POOL_BYTES + 1, FIELD_MAX));
                    2: push_free($urandom_range(0, FIELD_MAX));
                    3: push_free($urandom_range(0, NUM_UNITS - 1) * ALIGN_BYTES + HDR_SIZE);
                    default: push_free($urandom_range(0, NUM_UNITS + 3) * ALIGN_BYTES +
                                       HDR_SIZE + $urandom_range(1, ALIGN_BYTES - 1));
                endcase
            end
        end
    endtask

    initial
    begin
        int          k;
        int          idx;
        int unsigned addr;
        // shadow table after reset: one free block over the whole pool
        for (k = 0; k < NUM_UNITS; k++)
        begin
            blk_start[k] = 1'b0;
            blk_used[k]  = 1'b0;
            blk_units[k] = 0;
        end
        blk_start[0] = 1'b1;
        blk_units[0] = NUM_UNITS - HDR_UNITS;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed: bad sizes, whole-pool grant, split edges and bad frees
        push_alloc(0);
        push_alloc(POOL_BYTES + 1);
        push_alloc(FIELD_MAX);
        push_alloc(POOL_BYTES);
        push_alloc(POOL_BYTES - HDR_SIZE + 1);
        push_alloc(POOL_BYTES - HDR_SIZE);
        push_alloc(1);
        push_free(HDR_SIZE);
        push_free(HDR_SIZE);
        push_alloc(1);
        push_alloc(9);
        push_free(0);
        push_free(8);
        push_free(17);
        push_free(24);
        push_free(POOL_BYTES + HDR_SIZE);
        push_free(FIELD_MAX);
        push_free(HDR_SIZE);
        push_free(40);
        // remainder of exactly a header plus one unit still splits
        push_alloc(POOL_BYTES - HDR_SIZE - (HDR_UNITS + 1) * ALIGN_BYTES);
        push_alloc(ALIGN_BYTES);
        push_free(POOL_BYTES - ALIGN_BYTES);
        push_free(HDR_SIZE);
        // remainder one unit short of that does not split
        push_alloc(POOL_BYTES - HDR_SIZE - HDR_UNITS * ALIGN_BYTES);
        push_free(HDR_SIZE);
        wait_drained();
        live_blocks.delete();

        push_random_mix(250);
        wait_drained();

        // back-to-back stretch with no idling on either side
        calm_mode = 1'b1;
        push_random_mix(100);
        wait_drained();
        calm_mode = 1'b0;

        // fill toward exhaustion, then free everything in random order
        for (k = 0; k < 24; k++)
            push_alloc($urandom_range(1, 16384));
        wait_drained();
        while (live_blocks.size() > 0)
        begin
            idx  = $urandom_range(0, live_blocks.size() - 1);
            addr = live_blocks[idx];
            live_blocks.delete(idx);
            push_free(addr);
        end
        wait_drained();

        push_random_mix(200);
        wait_drained();
        repeat (40) @(negedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("first_fit_block_allocator_unit_test: clean");
        else
            $display("first_fit_block_allocator_unit_test: errors");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #50000000;
        $display("first_fit_block_allocator_unit_test: errors");
        $finish;
    end

endmodule
